>>> rtl/ahcf_pkg.sv
package ahcf_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] EOT_BYTE = 8'h04;

    // Register indexes on the configuration port (byte address is 4 * index)
    localparam logic [1:0] REG_BOARD_ADDRESS   = 2'd0;
    localparam logic [1:0] REG_CHECK_CHAR_HIGH = 2'd1;
    localparam logic [1:0] REG_CHECK_CHAR_LOW  = 2'd2;

    localparam logic [7:0] BOARD_ADDRESS_RST   = 8'h00;
    localparam logic [7:0] CHECK_CHAR_HIGH_RST = 8'h30;
    localparam logic [7:0] CHECK_CHAR_LOW_RST  = 8'h30;

    localparam logic [7:0] LETTER_P = 8'h50;
    localparam logic [7:0] LETTER_I = 8'h49;
    localparam logic [7:0] LETTER_T = 8'h54;
    localparam logic [7:0] LETTER_S = 8'h53;
    localparam logic [7:0] LETTER_L = 8'h4C;
    localparam logic [7:0] LETTER_D = 8'h44;
    localparam logic [7:0] LETTER_M = 8'h4D;
    localparam logic [7:0] LETTER_F = 8'h46;
    localparam logic [7:0] LETTER_R = 8'h52;
    localparam logic [7:0] LETTER_C = 8'h43;

    localparam logic [3:0] CODE_P = 4'd0;
    localparam logic [3:0] CODE_I = 4'd1;
    localparam logic [3:0] CODE_T = 4'd2;
    localparam logic [3:0] CODE_S = 4'd3;
    localparam logic [3:0] CODE_L = 4'd4;
    localparam logic [3:0] CODE_D = 4'd5;
    localparam logic [3:0] CODE_M = 4'd6;
    localparam logic [3:0] CODE_F = 4'd7;
    localparam logic [3:0] CODE_R = 4'd8;
    localparam logic [3:0] CODE_C = 4'd9;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_ADDR_HI  = 4'd1,
        ST_ADDR_LO  = 4'd2,
        ST_LETTER   = 4'd3,
        ST_P3       = 4'd4,
        ST_P2       = 4'd5,
        ST_P1       = 4'd6,
        ST_P0       = 4'd7,
        ST_CHK_HI   = 4'd8,
        ST_CHK_LO   = 4'd9,
        ST_WAIT_EOT = 4'd10,
        ST_RECOVER  = 4'd11
    } parse_state_t;

    typedef struct packed {
        logic [7:0] board_address;
        logic [7:0] check_char_high;
        logic [7:0] check_char_low;
    } cfg_t;

    typedef struct packed {
        logic        command_valid;
        logic [3:0]  command_code;
        logic [15:0] parameter_res;
        logic        unit_odd;
    } result_t;

    typedef struct packed {
        logic         found;
        logic [3:0]   code;
        parse_state_t first_state;
    } letter_dec_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_upper_hex(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h46);
    endfunction

    function automatic logic hex_ok(input logic [7:0] c);
        return is_digit(c) || is_upper_hex(c);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (is_upper_hex(c))
        begin
            d = c - 8'h37;
        end
        else if (is_digit(c))
        begin
            d = c - 8'h30;
        end
        return d[3:0];
    endfunction

    function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
        return {hex_val(hi), hex_val(lo)};
    endfunction

    function automatic parse_state_t recover(input logic [7:0] c);
        return (c == SOH_BYTE) ? ST_ADDR_HI : ST_IDLE;
    endfunction

    // Letters with no digits go straight to the check characters.
    function automatic letter_dec_t decode_letter(input logic [7:0] c);
        letter_dec_t d;
        d = '{found: 1'b1, code: CODE_P, first_state: ST_CHK_HI};
        unique case (c)
            LETTER_P: d = '{found: 1'b1, code: CODE_P, first_state: ST_CHK_HI};
            LETTER_I: d = '{found: 1'b1, code: CODE_I, first_state: ST_P3};
            LETTER_T: d = '{found: 1'b1, code: CODE_T, first_state: ST_CHK_HI};
            LETTER_S: d = '{found: 1'b1, code: CODE_S, first_state: ST_CHK_HI};
            LETTER_L: d = '{found: 1'b1, code: CODE_L, first_state: ST_CHK_HI};
            LETTER_D: d = '{found: 1'b1, code: CODE_D, first_state: ST_CHK_HI};
            LETTER_M: d = '{found: 1'b1, code: CODE_M, first_state: ST_P3};
            LETTER_F: d = '{found: 1'b1, code: CODE_F, first_state: ST_P1};
            LETTER_R: d = '{found: 1'b1, code: CODE_R, first_state: ST_P1};
            LETTER_C: d = '{found: 1'b1, code: CODE_C, first_state: ST_P1};
            default:  d = '{found: 1'b0, code: CODE_P, first_state: recover(c)};
        endcase
        return d;
    endfunction

endpackage

>>> rtl/ahcf_rx_if.sv
interface ahcf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/ahcf_cmd_if.sv
interface ahcf_cmd_if;
    logic        valid;
    logic        ready;
    logic        command_valid;
    logic [3:0]  command_code;
    logic [15:0] parameter_res;
    logic        unit_odd;

    modport source (
        output valid, output command_valid, output command_code,
        output parameter_res, output unit_odd, input ready
    );
    modport sink (
        input valid, input command_valid, input command_code,
        input parameter_res, input unit_odd, output ready
    );
endinterface

>>> rtl/ascii_hex_command_frame_parser_top.sv
// A result beat is registered in the output stage, or in its skid entry while the output is stalled.
// Throughput: one byte per cycle while the skid entry is empty, held by the single parse-state register.
// A two-entry output buffer keeps the input open while one result is stalled.
// Reset: parser in its recovery state, accumulators cleared, output buffer empty,
// configuration registers at their defaults (board address 0, check bytes 0x30).
module ascii_hex_command_frame_parser_top (
    input  logic                         clk,
    input  logic                         rst_n,
    ahcf_rx_if.sink                      rx,
    ahcf_cmd_if.source                   cmd,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ahcf_pkg::ADDR_W-1:0]  paddr,
    input  logic [ahcf_pkg::DATA_W-1:0]  pwdata,
    output logic [ahcf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    ahcf_pkg::cfg_t    cfg;
    ahcf_pkg::result_t res;
    logic              stage_ready;
    logic              accept;

    assign rx.ready = stage_ready;
    assign accept   = rx.valid && stage_ready;

    ahcf_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ahcf_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx.rx_byte),
        .cfg     (cfg),
        .res     (res)
    );

    ahcf_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .res   (res),
        .ready (stage_ready),
        .cmd   (cmd)
    );

endmodule

>>> rtl/ahcf_cfg_regs.sv
module ahcf_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ahcf_pkg::ADDR_W-1:0]  paddr,
    input  logic [ahcf_pkg::DATA_W-1:0]  pwdata,
    output logic [ahcf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output ahcf_pkg::cfg_t               cfg
);

    ahcf_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[ahcf_pkg::ADDR_W-1:2];
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.board_address   <= ahcf_pkg::BOARD_ADDRESS_RST;
            cfg_reg.check_char_high <= ahcf_pkg::CHECK_CHAR_HIGH_RST;
            cfg_reg.check_char_low  <= ahcf_pkg::CHECK_CHAR_LOW_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                ahcf_pkg::REG_BOARD_ADDRESS:   cfg_reg.board_address   <= pwdata[7:0];
                ahcf_pkg::REG_CHECK_CHAR_HIGH: cfg_reg.check_char_high <= pwdata[7:0];
                ahcf_pkg::REG_CHECK_CHAR_LOW:  cfg_reg.check_char_low  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            ahcf_pkg::REG_BOARD_ADDRESS:   prdata[7:0] = cfg_reg.board_address;
            ahcf_pkg::REG_CHECK_CHAR_HIGH: prdata[7:0] = cfg_reg.check_char_high;
            ahcf_pkg::REG_CHECK_CHAR_LOW:  prdata[7:0] = cfg_reg.check_char_low;
            default:                       prdata = '0;
        endcase
    end

endmodule

>>> rtl/ahcf_parser.sv
module ahcf_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    input  ahcf_pkg::cfg_t      cfg,
    output ahcf_pkg::result_t   res
);

    ahcf_pkg::parse_state_t state_reg, state_next;
    logic [7:0]             pending_reg, pending_next;
    logic [15:0]            acc_reg, acc_next;
    logic [3:0]             cmd_reg, cmd_next;
    logic                   unit_reg, unit_next;

    ahcf_pkg::letter_dec_t  letter;
    logic                   byte_hex;
    logic [7:0]             pair;
    logic [7:0]             frame_addr;

    assign letter     = ahcf_pkg::decode_letter(rx_byte);
    assign byte_hex   = ahcf_pkg::hex_ok(rx_byte);
    assign pair       = ahcf_pkg::hex_pair(pending_reg, rx_byte);
    assign frame_addr = pair;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ahcf_pkg::ST_RECOVER;
            pending_reg <= '0;
            acc_reg     <= '0;
            cmd_reg     <= '0;
            unit_reg    <= 1'b0;
        end
        else if (accept)
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
            cmd_reg     <= cmd_next;
            unit_reg    <= unit_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = ahcf_pkg::recover(rx_byte);
        unique case (state_reg)
            ahcf_pkg::ST_IDLE:
                state_next = (rx_byte == ahcf_pkg::SOH_BYTE) ? ahcf_pkg::ST_ADDR_HI
                                                             : ahcf_pkg::ST_IDLE;
            ahcf_pkg::ST_ADDR_HI:
                if (byte_hex)
                begin
                    state_next = ahcf_pkg::ST_ADDR_LO;
                end
            ahcf_pkg::ST_ADDR_LO:
                if (byte_hex)
                begin
                    // Bit 0 only picks the unit, so it takes no part in the match.
                    state_next = ({frame_addr[7:1], 1'b0} == cfg.board_address)
                               ? ahcf_pkg::ST_LETTER : ahcf_pkg::ST_IDLE;
                end
            ahcf_pkg::ST_LETTER:
                state_next = letter.first_state;
            ahcf_pkg::ST_P3:
                if (byte_hex)
                begin
                    state_next = ahcf_pkg::ST_P2;
                end
            ahcf_pkg::ST_P2:
                if (byte_hex)
                begin
                    state_next = ahcf_pkg::ST_P1;
                end
            ahcf_pkg::ST_P1:
                if (byte_hex)
                begin
                    state_next = ahcf_pkg::ST_P0;
                end
            ahcf_pkg::ST_P0:
                if (byte_hex)
                begin
                    state_next = ahcf_pkg::ST_CHK_HI;
                end
            ahcf_pkg::ST_CHK_HI:
                if (rx_byte == cfg.check_char_high)
                begin
                    state_next = ahcf_pkg::ST_CHK_LO;
                end
            ahcf_pkg::ST_CHK_LO:
                if (rx_byte == cfg.check_char_low)
                begin
                    state_next = ahcf_pkg::ST_WAIT_EOT;
                end
            ahcf_pkg::ST_WAIT_EOT:
                if (rx_byte == ahcf_pkg::EOT_BYTE)
                begin
                    state_next = ahcf_pkg::ST_IDLE;
                end
            default:
                state_next = ahcf_pkg::recover(rx_byte);
        endcase
    end

    // Datapath and result
    always_comb
    begin
        pending_next = pending_reg;
        acc_next     = acc_reg;
        cmd_next     = cmd_reg;
        unit_next    = unit_reg;
        res          = '0;
        unique case (state_reg)
            ahcf_pkg::ST_ADDR_HI, ahcf_pkg::ST_P3, ahcf_pkg::ST_P1:
                if (byte_hex)
                begin
                    pending_next = rx_byte;
                end
            ahcf_pkg::ST_ADDR_LO:
                if (byte_hex)
                begin
                    unit_next = frame_addr[0];
                end
            ahcf_pkg::ST_LETTER:
                if (letter.found)
                begin
                    cmd_next     = letter.code;
                    pending_next = '0;
                    acc_next     = '0;
                end
            ahcf_pkg::ST_P2:
                if (byte_hex)
                begin
                    acc_next = {pair, 8'h00};
                end
            ahcf_pkg::ST_P0:
                if (byte_hex)
                begin
                    acc_next = acc_reg + {8'h00, pair};
                end
            ahcf_pkg::ST_WAIT_EOT:
                if (rx_byte == ahcf_pkg::EOT_BYTE)
                begin
                    res.command_valid = 1'b1;
                    res.command_code  = cmd_reg;
                    res.parameter_res = acc_reg;
                end
            default: ;
        endcase
        res.unit_odd = unit_next;
    end

endmodule

>>> rtl/ahcf_out_stage.sv
module ahcf_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ahcf_pkg::result_t   res,
    output logic                ready,
    ahcf_cmd_if.source          cmd
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    ahcf_pkg::result_t out_data_reg, out_data_next;
    ahcf_pkg::result_t skid_data_reg, skid_data_next;
    logic              pop;

    // The skid entry takes a beat that arrives while the output is stalled.
    assign ready = !skid_valid_reg;
    assign pop   = out_valid_reg && cmd.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            out_valid_next  = skid_valid_reg;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (push)
        begin
            if (out_valid_reg && !cmd.ready)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign cmd.valid         = out_valid_reg;
    assign cmd.command_valid = out_data_reg.command_valid;
    assign cmd.command_code  = out_data_reg.command_code;
    assign cmd.parameter_res = out_data_reg.parameter_res;
    assign cmd.unit_odd      = out_data_reg.unit_odd;

endmodule

>>> sim/ascii_hex_command_frame_parser_top_test.sv
module ascii_hex_command_frame_parser_top_test;

    typedef enum logic [1:0] {
        GAPS_NONE,
        GAPS_SENDER,
        GAPS_RECEIVER,
        GAPS_BOTH
    } gap_mode_t;

    typedef struct {
        logic [7:0]        rx;
        bit                typed;
        ahcf_pkg::result_t want;
    } stim_row_t;

    localparam int HOLD_CYCLES = 50;

    // Command letters packed by command code, code 0 in the lowest byte.
    localparam logic [79:0] LETTER_ROW = {
        ahcf_pkg::LETTER_C, ahcf_pkg::LETTER_R, ahcf_pkg::LETTER_F, ahcf_pkg::LETTER_M,
        ahcf_pkg::LETTER_D, ahcf_pkg::LETTER_L, ahcf_pkg::LETTER_S, ahcf_pkg::LETTER_T,
        ahcf_pkg::LETTER_I, ahcf_pkg::LETTER_P
    };

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ahcf_pkg::ADDR_W-1:0] paddr;
    logic [ahcf_pkg::DATA_W-1:0] pwdata;
    logic [ahcf_pkg::DATA_W-1:0] prdata;
    logic pready;

    ahcf_rx_if rx_ch();
    ahcf_cmd_if cmd_ch();

    ascii_hex_command_frame_parser_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch.sink),
        .cmd     (cmd_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state and its copy of the registers.
    ahcf_pkg::parse_state_t fsm_st;
    logic [7:0]             pend_char;
    logic [15:0]            param_acc;
    logic [3:0]             cmd_idx;
    logic                   unit_flag;
    ahcf_pkg::cfg_t         cfg_now;

    ahcf_pkg::result_t      pending_cmds[$];
    stim_row_t              stim_rows[$];
    logic [7:0]             frame_q[$];
    gap_mode_t              idle_mode;
    int                     mismatches;
    int                     beats_seen;
    int                     hold_reqs;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit is_hex_char(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]}) || (c inside {[8'h41:8'h46]});
    endfunction

    function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] h;
        logic [7:0] l;
        h = (hi >= 8'h41) ? hi - 8'h37 : hi - 8'h30;
        l = (lo >= 8'h41) ? lo - 8'h37 : lo - 8'h30;
        return {h[3:0], l[3:0]};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
    endfunction

    function automatic int digits_for(input logic [3:0] code);
        if (code == ahcf_pkg::CODE_I || code == ahcf_pkg::CODE_M)
            return 4;
        if (code == ahcf_pkg::CODE_F || code == ahcf_pkg::CODE_R || code == ahcf_pkg::CODE_C)
            return 2;
        return 0;
    endfunction

    function automatic ahcf_pkg::parse_state_t resync(input logic [7:0] c);
        return (c == ahcf_pkg::SOH_BYTE) ? ahcf_pkg::ST_ADDR_HI : ahcf_pkg::ST_IDLE;
    endfunction

    // Advances the parser copy by one byte and returns the command beat it causes.
    function automatic ahcf_pkg::result_t decode_rx_byte(input logic [7:0] c);
        ahcf_pkg::result_t r;
        logic [7:0]        a;
        bit                found;
        int                k;
        r = '0;
        case (fsm_st)
            ahcf_pkg::ST_IDLE:
            begin
                if (c == ahcf_pkg::SOH_BYTE)
                    fsm_st = ahcf_pkg::ST_ADDR_HI;
            end
            ahcf_pkg::ST_ADDR_HI:
            begin
                if (is_hex_char(c))
                begin
                    pend_char = c;
                    fsm_st = ahcf_pkg::ST_ADDR_LO;
                end
                else
                    fsm_st = resync(c);
            end
            ahcf_pkg::ST_ADDR_LO:
            begin
                if (is_hex_char(c))
                begin
                    a = pair_value(pend_char, c);
                    unit_flag = a[0];
                    fsm_st = ({a[7:1], 1'b0} == cfg_now.board_address)
                           ? ahcf_pkg::ST_LETTER : ahcf_pkg::ST_IDLE;
                end
                else
                    fsm_st = resync(c);
            end
            ahcf_pkg::ST_LETTER:
            begin
                found = 1'b0;
                fsm_st = resync(c);
                for (k = 0; k < 10 && !found; k++)
                begin
                    if (c == LETTER_ROW[k*8 +: 8])
                    begin
                        found = 1'b1;
                        cmd_idx = 4'(k);
                        pend_char = '0;
                        param_acc = '0;
                        case (digits_for(4'(k)))
                            4: fsm_st = ahcf_pkg::ST_P3;
                            2: fsm_st = ahcf_pkg::ST_P1;
                            default: fsm_st = ahcf_pkg::ST_CHK_HI;
                        endcase
                    end
                end
            end
            ahcf_pkg::ST_P3, ahcf_pkg::ST_P1:
            begin
                if (is_hex_char(c))
                begin
                    pend_char = c;
                    fsm_st = (fsm_st == ahcf_pkg::ST_P3) ? ahcf_pkg::ST_P2 : ahcf_pkg::ST_P0;
                end
                else
                    fsm_st = resync(c);
            end
            ahcf_pkg::ST_P2:
            begin
                if (is_hex_char(c))
                begin
                    param_acc = {pair_value(pend_char, c), 8'h00};
                    fsm_st = ahcf_pkg::ST_P1;
                end
                else
                    fsm_st = resync(c);
            end
            ahcf_pkg::ST_P0:
            begin
                if (is_hex_char(c))
                begin
                    param_acc = param_acc + {8'h00, pair_value(pend_char, c)};
                    fsm_st = ahcf_pkg::ST_CHK_HI;
                end
                else
                    fsm_st = resync(c);
            end
            ahcf_pkg::ST_CHK_HI:
                fsm_st = (c == cfg_now.check_char_high) ? ahcf_pkg::ST_CHK_LO : resync(c);
            ahcf_pkg::ST_CHK_LO:
                fsm_st = (c == cfg_now.check_char_low) ? ahcf_pkg::ST_WAIT_EOT : resync(c);
            ahcf_pkg::ST_WAIT_EOT:
            begin
                if (c == ahcf_pkg::EOT_BYTE)
                begin
                    r.command_valid = 1'b1;
                    r.command_code = cmd_idx;
                    r.parameter_res = param_acc;
                    fsm_st = ahcf_pkg::ST_IDLE;
                end
                else
                    fsm_st = resync(c);
            end
            default:
                fsm_st = resync(c);
        endcase
        r.unit_odd = unit_flag;
        return r;
    endfunction

    function automatic bit gap_roll(input bit receiver_side);
        int pct;
        case (idle_mode)
            GAPS_SENDER:   pct = receiver_side ? 0 : 57;
            GAPS_RECEIVER: pct = receiver_side ? 57 : 0;
            GAPS_BOTH:     pct = 11;
            default:       pct = 0;
        endcase
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic add_row(input logic [7:0] b, input bit typed = 1'b0,
                           input ahcf_pkg::result_t r = '0);
        stim_row_t row;
        row.rx = b;
        row.typed = typed;
        row.want = r;
        stim_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'h000000, val};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            ahcf_pkg::REG_BOARD_ADDRESS:   cfg_now.board_address = val;
            ahcf_pkg::REG_CHECK_CHAR_HIGH: cfg_now.check_char_high = val;
            ahcf_pkg::REG_CHECK_CHAR_LOW:  cfg_now.check_char_low = val;
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offers one byte and, once it is taken, records the beat it must produce.
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input ahcf_pkg::result_t want);
        ahcf_pkg::result_t r;
        @(negedge clk);
        while (gap_roll(1'b0))
        begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        r = decode_rx_byte(b);
        pending_cmds.push_back(typed ? want : r);
    endtask

    task automatic drain_results();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        wait (pending_cmds.size() == 0);
    endtask

    // Builds one frame for the current registers, now and then damaged.
    task automatic build_frame();
        logic [7:0] addr;
        logic [3:0] code;
        int         pos;
        int         roll;
        int         k;
        frame_q.delete();
        if ($urandom_range(0, 9) < 7)
            addr = {cfg_now.board_address[7:1], 1'($urandom_range(0, 1))};
        else
            addr = 8'($urandom_range(0, 255));
        code = 4'($urandom_range(0, 9));
        frame_q.push_back(ahcf_pkg::SOH_BYTE);
        frame_q.push_back(hex_char(addr[7:4]));
        frame_q.push_back(hex_char(addr[3:0]));
        frame_q.push_back(LETTER_ROW[code*8 +: 8]);
        for (k = 0; k < digits_for(code); k++)
            frame_q.push_back(hex_char(4'($urandom_range(0, 15))));
        frame_q.push_back(cfg_now.check_char_high);
        frame_q.push_back(cfg_now.check_char_low);
        frame_q.push_back(ahcf_pkg::EOT_BYTE);
        roll = $urandom_range(0, 99);
        pos = $urandom_range(1, frame_q.size() - 1);
        if (roll < 12)
            frame_q[pos] = 8'($urandom_range(0, 255));
        else if (roll < 18)
            frame_q[pos] = 8'h61 + 8'($urandom_range(0, 5));
        else if (roll < 24)
        begin
            while (frame_q.size() > pos)
                void'(frame_q.pop_back());
        end
    endtask

    task automatic run_phase(input logic [7:0] board, input logic [7:0] chk_hi,
                             input logic [7:0] chk_lo, input gap_mode_t mode,
                             input int nbytes, input bit pressure);
        int sent;
        int k;
        bit held;
        bit paused;
        write_reg(ahcf_pkg::REG_BOARD_ADDRESS, board);
        write_reg(ahcf_pkg::REG_CHECK_CHAR_HIGH, chk_hi);
        write_reg(ahcf_pkg::REG_CHECK_CHAR_LOW, chk_lo);
        idle_mode = mode;
        sent = 0;
        held = 1'b0;
        paused = 1'b0;
        while (sent < nbytes)
        begin
            if (pressure && !held && sent >= 30)
            begin
                held = 1'b1;
                hold_reqs++;
            end
            if (pressure && !paused && sent >= nbytes / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
            if ($urandom_range(0, 99) < 15)
            begin
                for (k = $urandom_range(1, 4); k > 0; k--)
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                    sent++;
                end
            end
            build_frame();
            foreach (frame_q[k])
                send_byte(frame_q[k], 1'b0, '0);
            sent += frame_q.size();
        end
        drain_results();
    endtask

    // Receiver side: random stalls, plus one long hold-off when asked for.
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        cmd_ch.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                cmd_ch.ready <= 1'b0;
            end
            else
                cmd_ch.ready <= !gap_roll(1'b1);
        end
    end

    always @(posedge clk)
    begin : check_beats
        ahcf_pkg::result_t got;
        ahcf_pkg::result_t want;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            got.command_valid = cmd_ch.command_valid;
            got.command_code = cmd_ch.command_code;
            got.parameter_res = cmd_ch.parameter_res;
            got.unit_odd = cmd_ch.unit_odd;
            beats_seen++;
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d: unexpected command beat %h", beats_seen, got);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (got.command_valid !== want.command_valid
                    || got.command_code !== want.command_code
                    || got.parameter_res !== want.parameter_res
                    || got.unit_odd !== want.unit_odd)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: expected valid %0b code %0d param %h unit %0b, %s",
                                 beats_seen, want.command_valid, want.command_code,
                                 want.parameter_res, want.unit_odd,
                                 $sformatf("got valid %0b code %0d param %h unit %0b",
                                           got.command_valid, got.command_code,
                                           got.parameter_res, got.unit_odd));
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [7:0] even_addr;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = 8'h00;
        idle_mode = GAPS_NONE;
        mismatches = 0;
        beats_seen = 0;
        hold_reqs = 0;
        fsm_st = ahcf_pkg::ST_RECOVER;
        pend_char = '0;
        param_acc = '0;
        cmd_idx = '0;
        unit_flag = 1'b0;
        cfg_now.board_address = ahcf_pkg::BOARD_ADDRESS_RST;
        cfg_now.check_char_high = ahcf_pkg::CHECK_CHAR_HIGH_RST;
        cfg_now.check_char_low = ahcf_pkg::CHECK_CHAR_LOW_RST;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Straight after reset, with the default registers.
        add_row(8'h00, 1'b1, '0);
        add_row(ahcf_pkg::SOH_BYTE);
        add_row(8'h30);
        add_row(8'h31);
        add_row(ahcf_pkg::LETTER_I);
        repeat (4) add_row(8'h46);
        add_row(8'h30);
        add_row(8'h30);
        add_row(ahcf_pkg::EOT_BYTE, 1'b1, {1'b1, ahcf_pkg::CODE_I, 16'hFFFF, 1'b1});
        // Address FF does not match board 0 but still marks the odd unit.
        add_row(ahcf_pkg::SOH_BYTE);
        add_row(8'h46);
        add_row(8'h46);
        // Lowercase hex in the address is illegal.
        add_row(ahcf_pkg::SOH_BYTE);
        add_row(8'h61, 1'b1, {1'b0, 4'd0, 16'h0000, 1'b1});
        // A letter outside the table aborts the frame.
        add_row(ahcf_pkg::SOH_BYTE);
        add_row(8'h30);
        add_row(8'h30);
        add_row(8'h70, 1'b1, '0);
        // SOH in the middle of a frame starts a new one.
        add_row(ahcf_pkg::SOH_BYTE);
        add_row(8'h30);
        add_row(8'h30);
        add_row(ahcf_pkg::LETTER_C);
        add_row(ahcf_pkg::SOH_BYTE);
        add_row(8'h30);
        add_row(8'h30);
        add_row(ahcf_pkg::LETTER_P);
        add_row(8'h30);
        add_row(8'h30);
        add_row(ahcf_pkg::EOT_BYTE, 1'b1, {1'b1, ahcf_pkg::CODE_P, 16'h0000, 1'b0});

        foreach (stim_rows[i])
            send_byte(stim_rows[i].rx, stim_rows[i].typed, stim_rows[i].want);
        drain_results();

        run_phase(8'h00, 8'h00, 8'hFF, GAPS_NONE, 150, 1'b1);
        run_phase(8'hFE, 8'hFF, 8'h00, GAPS_SENDER, 150, 1'b0);
        even_addr = {7'($urandom_range(0, 127)), 1'b0};
        run_phase(even_addr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  GAPS_RECEIVER, 150, 1'b0);
        // An odd board address never matches any frame.
        run_phase(8'h33, 8'h30, 8'h30, GAPS_BOTH, 120, 1'b0);
        even_addr = {7'($urandom_range(0, 127)), 1'b0};
        run_phase(even_addr, ahcf_pkg::EOT_BYTE, ahcf_pkg::SOH_BYTE, GAPS_BOTH, 150, 1'b0);
        run_phase(ahcf_pkg::BOARD_ADDRESS_RST, ahcf_pkg::CHECK_CHAR_HIGH_RST,
                  ahcf_pkg::CHECK_CHAR_LOW_RST, GAPS_NONE, 150, 1'b0);

        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ahcf_pkg.sv
rtl/ahcf_rx_if.sv
rtl/ahcf_cmd_if.sv
rtl/ahcf_cfg_regs.sv
rtl/ahcf_parser.sv
rtl/ahcf_out_stage.sv
rtl/ascii_hex_command_frame_parser_top.sv
sim/ascii_hex_command_frame_parser_top_test.sv
